// ----- design/ers_pkg.sv -----
// Shared widths, register indexes, reset values and control types for echo range statistics.
package ers_pkg;

  // Field and datapath widths.
  localparam int WidthW  = 16;
  localparam int SpeedW  = 12;
  localparam int RangeW  = 19;
  localparam int DistW   = 20;
  localparam int ProdW   = WidthW + SpeedW;
  localparam int SumW    = 27;
  localparam int CountW  = 8;
  localparam int CfgIdxW = 2;

  // The distance is the product with eight fractional bits dropped.
  localparam int DistShift = 8;

  // Restoring divider: one quotient bit per step over the whole sum.
  localparam int DivSteps = SumW;
  localparam int StepW    = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMinRange  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxRange  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHalfSpeed = 2'd2;

  // Configuration reset values.
  localparam logic [RangeW-1:0] MinRangeRst  = 19'd512;
  localparam logic [RangeW-1:0] MaxRangeRst  = 19'd102400;
  localparam logic [SpeedW-1:0] HalfSpeedRst = 12'd1114;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul;
    logic acc;
    logic div_start;
    logic div_step;
    logic load_out;
  } ers_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic div_done;
  } ers_status_t;

endpackage

// ----- design/ers_in_if.sv -----
// Input channel carrying one echo width transaction.
interface ers_in_if;
  logic                       valid;
  logic                       ready;
  logic [ers_pkg::WidthW-1:0] echo_width;
  logic                       last;

  modport source (output valid, output echo_width, output last, input ready);
  modport sink (input valid, input echo_width, input last, output ready);
endinterface

// ----- design/ers_out_if.sv -----
// Output channel carrying one run statistics transaction.
interface ers_out_if;
  logic                       valid;
  logic                       ready;
  logic [ers_pkg::RangeW-1:0] avg_range;
  logic [ers_pkg::RangeW-1:0] min_range_seen;
  logic [ers_pkg::RangeW-1:0] max_range_seen;
  logic [ers_pkg::CountW-1:0] valid_count;
  logic                       any_valid;

  modport source (output valid, output avg_range, output min_range_seen,
                  output max_range_seen, output valid_count, output any_valid,
                  input ready);
  modport sink (input valid, input avg_range, input min_range_seen,
                input max_range_seen, input valid_count, input any_valid,
                output ready);
endinterface

// ----- design/ers_dpath.sv -----
// Datapath: configuration, distance multiply, run accumulation, divider and result register.
module ers_dpath import ers_pkg::*; #(
  parameter int unsigned MaxSamples = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [RangeW-1:0]   cfg_wdata_i,
  input  logic [WidthW-1:0]   echo_width_i,
  input  logic                last_i,
  input  ers_cmd_t            cmd_i,
  output ers_status_t         status_o,
  output logic [RangeW-1:0]   avg_range_o,
  output logic [RangeW-1:0]   min_range_seen_o,
  output logic [RangeW-1:0]   max_range_seen_o,
  output logic [CountW-1:0]   valid_count_o,
  output logic                any_valid_o
);

  // The 8-bit counter caps the in-window readings of a run at MaxSamples, at most 255.
  localparam logic [CountW-1:0] CountLimit =
      CountW'((MaxSamples < 255) ? MaxSamples : 255);

  logic [RangeW-1:0] min_range_q;
  logic [RangeW-1:0] max_range_q;
  logic [SpeedW-1:0] half_speed_q;

  logic [WidthW-1:0] width_q;
  logic              last_q;
  logic [ProdW-1:0]  prod;
  logic [DistW-1:0]  dist_q;
  logic              nz_q;

  logic              in_window;
  logic              take;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  logic [RangeW-1:0] low_q;
  logic [RangeW-1:0] high_q;

  logic [CountW-1:0] rem_q;
  logic [SumW-1:0]   quo_q;
  logic [StepW-1:0]  step_q;
  logic [CountW:0]   rem_shift;
  logic              rem_ge;
  logic [CountW:0]   rem_diff;

  logic              run_any;
  logic [RangeW-1:0] out_avg_q;
  logic [RangeW-1:0] out_min_q;
  logic [RangeW-1:0] out_max_q;
  logic [CountW-1:0] out_count_q;
  logic              out_any_q;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q  <= MinRangeRst;
      max_range_q  <= MaxRangeRst;
      half_speed_q <= HalfSpeedRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMinRange:  min_range_q  <= cfg_wdata_i;
        CfgMaxRange:  max_range_q  <= cfg_wdata_i;
        CfgHalfSpeed: half_speed_q <= cfg_wdata_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      width_q <= echo_width_i;
    end
  end

  // Width times half speed, registered as a distance in 1/256 cm.
  assign prod = ProdW'(width_q) * ProdW'(half_speed_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      dist_q <= prod[ProdW-1:DistShift];
      nz_q   <= (width_q != '0);
    end
  end

  // Window test; a timeout never counts and the count stops at its cap.
  assign in_window = nz_q && (dist_q >= {1'b0, min_range_q}) &&
                     (dist_q <= {1'b0, max_range_q});
  assign take      = in_window && (count_q < CountLimit);

  // Run accumulators, cleared when the result is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      low_q   <= '1;
      high_q  <= '0;
    end else if (cmd_i.load_out) begin
      sum_q   <= '0;
      count_q <= '0;
      low_q   <= '1;
      high_q  <= '0;
    end else if (cmd_i.acc && take) begin
      sum_q   <= sum_q + SumW'(dist_q);
      count_q <= count_q + CountW'(1);
      if (dist_q[RangeW-1:0] < low_q) begin
        low_q <= dist_q[RangeW-1:0];
      end
      if (dist_q[RangeW-1:0] > high_q) begin
        high_q <= dist_q[RangeW-1:0];
      end
    end
  end

  // Restoring divider step: shift in the next sum bit and try a subtract.
  assign rem_shift = {rem_q, quo_q[SumW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, count_q});
  assign rem_diff  = rem_shift - {1'b0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_diff[CountW-1:0] : rem_shift[CountW-1:0];
      quo_q <= {quo_q[SumW-2:0], rem_ge};
    end
  end

  assign status_o.last     = last_q;
  assign status_o.div_done = (step_q == StepW'(DivSteps - 1));

  // Result register; an empty run reports all zeros.
  assign run_any = (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_any_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_any_q <= run_any;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_avg_q   <= run_any ? quo_q[RangeW-1:0] : '0;
      out_min_q   <= run_any ? low_q : '0;
      out_max_q   <= run_any ? high_q : '0;
      out_count_q <= count_q;
    end
  end

  assign avg_range_o      = out_avg_q;
  assign min_range_seen_o = out_min_q;
  assign max_range_seen_o = out_max_q;
  assign valid_count_o    = out_count_q;
  assign any_valid_o      = out_any_q;

  // The counter never passes its cap.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountLimit)
    else $error("sample count above its cap");

  // A non-empty result has its minimum at or below its maximum.
  a_out_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_any_q |-> (out_min_q <= out_max_q))
    else $error("result minimum above maximum");

  // The divider step counter stops once every quotient bit is formed.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepW'(DivSteps))
    else $error("divider ran past its last step");

endmodule

// ----- design/ers_ctrl.sv -----
// Controller: sequences accept, multiply, accumulate, divide and result handoff.
module ers_ctrl import ers_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ers_status_t status_i,
  output ers_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIVL = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (status_i.last) begin
          state_d = S_DIVL;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load_in = 1'b1;
            state_d       = S_MUL;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DIVL: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid is set on a load and dropped once the transaction is taken.
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new result never overwrites one that has not been taken.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  // A final reading always leads into the divide.
  a_last_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && status_i.last) |=> (state_q == S_DIVL))
    else $error("final reading did not start the divide");

  // A result appears only out of the handoff state.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result valid raised outside the handoff state");

endmodule

// ----- design/echo_range_statistics.sv -----
// Echo range statistics: converts echo widths to distances and reports per-run statistics.
// Each echo width is scaled by half_speed into a distance in 1/256 cm; distances inside
// the configured window are summed, counted and tracked for minimum and maximum. A reading
// that is not marked last passes the multiply stage and the accumulate stage, where the next
// transaction is accepted. A reading marked last passes accept, multiply, accumulate, divider
// load, 27 divider steps and result load before the next transaction is accepted, and the
// result load waits while a still pending result has not been taken by the output. The mean
// is formed by a 27-step restoring divider. The result register holds one finished result
// while the next run is being collected. Configuration is written through cfg_we_i, cfg_idx_i
// and cfg_wdata_i; users write it only while the block is idle, which it does not enforce.
module echo_range_statistics import ers_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RangeW-1:0]  cfg_wdata_i,
  ers_in_if.sink             in_ch,
  ers_out_if.source          out_ch
);

  ers_cmd_t    cmd;
  ers_status_t status;

  // Sequencer.
  ers_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  ers_dpath #(
    .MaxSamples (MAX_SAMPLES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .echo_width_i     (in_ch.echo_width),
    .last_i           (in_ch.last),
    .cmd_i            (cmd),
    .status_o         (status),
    .avg_range_o      (out_ch.avg_range),
    .min_range_seen_o (out_ch.min_range_seen),
    .max_range_seen_o (out_ch.max_range_seen),
    .valid_count_o    (out_ch.valid_count),
    .any_valid_o      (out_ch.any_valid)
  );

endmodule
